// ===== hdl/p2fl_pkg.sv =====
// Package for the power-of-two free list allocator.
// Holds sizing constants, beat and entry types, codes and offset helpers.
// Used by every module of the block; depends on nothing.
package p2fl_pkg;

    localparam int LIST_DEPTH  = 256;
    localparam int OFFSET_BITS = 40;

    localparam int IDX_W   = $clog2(LIST_DEPTH);
    localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
    localparam int ALU_W   = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 1;
    localparam int PWR_W   = 5;
    localparam int REG_W   = 40;
    localparam int REQ_W   = 31;
    localparam int STAT_W  = 4;
    localparam int FCNT_W  = 9;
    localparam int PDATA_W = 64;
    localparam int PADDR_W = 3;

    localparam logic [PWR_W-1:0]   MAX_POWER = 5'd31;
    localparam logic [PADDR_W-1:0] ADDR_INIT_END = 3'd0;

    typedef enum logic [1:0] {
        OP_RELEASE = 2'd0,
        OP_RESIZE  = 2'd1,
        OP_LOOKUP  = 2'd2
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_NO_CHANGE   = 4'd0,
        ST_RELEASED    = 4'd1,
        ST_IGNORED     = 4'd2,
        ST_FROM_LIST   = 4'd3,
        ST_AT_END      = 4'd4,
        ST_FOUND       = 4'd5,
        ST_NOT_FOUND   = 4'd6,
        ST_LIST_FULL   = 4'd7,
        ST_END_OVERFLOW = 4'd8
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ROUND,
        S_SRCH_ADDR,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_END_CHK,
        S_APPEND,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [PWR_W-1:0] block_size_power;
        logic [REQ_W-1:0] need_bytes;
        logic [REG_W-1:0] current_offset;
        logic             entry_loaded;
    } t_cmd;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [REG_W-1:0]  new_offset;
        logic [PWR_W-1:0]  new_size_power;
        logic [FCNT_W-1:0] free_count;
    } t_result;

    typedef struct packed {
        logic [PWR_W-1:0]       power;
        logic [OFFSET_BITS-1:0] offset;
    } t_entry;

    typedef struct packed {
        logic [ALU_W-1:0] opa;
        logic [ALU_W-1:0] opb;
        logic [ALU_W-1:0] opc;
    } t_alu_in;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             lt;
        logic             eq;
    } t_alu_out;

    function automatic logic [OFFSET_BITS-1:0] to_off(input logic [REG_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[OFFSET_BITS-1:0];
    endfunction

    function automatic logic [REG_W-1:0] from_off(input logic [OFFSET_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[REG_W-1:0];
    endfunction

endpackage

// ===== hdl/p2fl_alu.sv =====
// Shared add-and-compare unit of the allocator sequencer.
// Computes opa + opb and compares the sum against opc; uses p2fl_pkg.
module p2fl_alu (
    input  p2fl_pkg::t_alu_in  i_req,
    output p2fl_pkg::t_alu_out o_res
);

    logic [p2fl_pkg::ALU_W-1:0] sum;

    assign sum       = i_req.opa + i_req.opb;
    assign o_res.sum = sum;
    assign o_res.lt  = sum < i_req.opc;
    assign o_res.eq  = sum == i_req.opc;

endmodule

// ===== hdl/p2fl_mem.sv =====
// Free list storage: one write port and one read port with registered data.
// Entry type and depth come from p2fl_pkg.
module p2fl_mem (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [p2fl_pkg::IDX_W-1:0] i_waddr,
    input  p2fl_pkg::t_entry           i_wdata,
    input  logic [p2fl_pkg::IDX_W-1:0] i_raddr,
    output p2fl_pkg::t_entry           o_rdata
);

    p2fl_pkg::t_entry r_mem [p2fl_pkg::LIST_DEPTH];
    p2fl_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/p2fl_seq.sv =====
// Sequencer of the allocator: walks the free list one entry at a time,
// closes gaps, appends blocks and moves the end pointer.
// Uses p2fl_pkg, p2fl_alu and p2fl_mem.
module p2fl_seq (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  p2fl_pkg::t_cmd                   i_cmd,
    input  logic                             i_cfg_we,
    input  logic [p2fl_pkg::OFFSET_BITS-1:0] i_cfg_end,
    output logic                             o_busy,
    output logic                             o_done,
    output p2fl_pkg::t_result                o_result
);

    p2fl_pkg::t_state r_state, n_state;

    logic [1:0]                       r_op, n_op;
    logic [p2fl_pkg::PWR_W-1:0]       r_pw, n_pw;
    logic [p2fl_pkg::REQ_W-1:0]       r_req, n_req;
    logic [p2fl_pkg::OFFSET_BITS-1:0] r_off, n_off;
    logic                             r_loaded, n_loaded;
    logic [p2fl_pkg::PWR_W-1:0]       r_np, n_np;
    logic [p2fl_pkg::CNT_W-1:0]       r_idx, n_idx;
    logic [p2fl_pkg::CNT_W-1:0]       r_count, n_count;
    logic [p2fl_pkg::OFFSET_BITS-1:0] r_end, n_end;
    p2fl_pkg::t_status                r_status, n_status;
    logic [p2fl_pkg::OFFSET_BITS-1:0] r_noff, n_noff;
    logic [p2fl_pkg::PWR_W-1:0]       r_npw, n_npw;

    logic                       accept;
    logic                       full;
    logic [p2fl_pkg::CNT_W-1:0] idx_inc;
    logic                       mem_we;
    logic [p2fl_pkg::IDX_W-1:0] mem_waddr;
    logic [p2fl_pkg::IDX_W-1:0] mem_raddr;
    p2fl_pkg::t_entry           mem_wdata;
    p2fl_pkg::t_entry           mem_rdata;
    p2fl_pkg::t_alu_in          alu_in;
    p2fl_pkg::t_alu_out         alu_out;

    p2fl_alu u_alu (
        .i_req (alu_in),
        .o_res (alu_out)
    );

    p2fl_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_busy  = (r_state != p2fl_pkg::S_IDLE) && (r_state != p2fl_pkg::S_DONE);
    assign accept  = i_start && !o_busy;
    assign full    = r_count == p2fl_pkg::CNT_W'(p2fl_pkg::LIST_DEPTH);
    assign idx_inc = r_idx + p2fl_pkg::CNT_W'(1);

    // Operands of the shared unit; only the active state's comparison is used.
    always_comb begin
        alu_in = '0;
        case (r_state)
            p2fl_pkg::S_DISPATCH: begin
                alu_in.opa = p2fl_pkg::ALU_W'(1) << r_pw;
                alu_in.opc = p2fl_pkg::ALU_W'(r_req);
            end
            p2fl_pkg::S_ROUND: begin
                alu_in.opa = p2fl_pkg::ALU_W'(1) << r_np;
                alu_in.opc = p2fl_pkg::ALU_W'(r_req);
            end
            p2fl_pkg::S_SRCH_CMP: begin
                alu_in.opa = p2fl_pkg::ALU_W'(mem_rdata.power);
                alu_in.opc = p2fl_pkg::ALU_W'(r_np);
            end
            p2fl_pkg::S_END_CHK: begin
                alu_in.opa = p2fl_pkg::ALU_W'(r_end);
                alu_in.opb = p2fl_pkg::ALU_W'(1) << r_np;
                alu_in.opc = p2fl_pkg::ALU_W'(1) << p2fl_pkg::OFFSET_BITS;
            end
            default: begin
                alu_in = '0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            p2fl_pkg::S_IDLE, p2fl_pkg::S_DONE: begin
                n_state = accept ? p2fl_pkg::S_DISPATCH : p2fl_pkg::S_IDLE;
            end
            p2fl_pkg::S_DISPATCH: begin
                case (r_op)
                    p2fl_pkg::OP_RELEASE: begin
                        n_state = (r_loaded && !full) ? p2fl_pkg::S_APPEND : p2fl_pkg::S_DONE;
                    end
                    p2fl_pkg::OP_RESIZE: begin
                        n_state = alu_out.lt ? p2fl_pkg::S_ROUND : p2fl_pkg::S_DONE;
                    end
                    p2fl_pkg::OP_LOOKUP: begin
                        n_state = p2fl_pkg::S_SRCH_ADDR;
                    end
                    default: begin
                        n_state = p2fl_pkg::S_DONE;
                    end
                endcase
            end
            p2fl_pkg::S_ROUND: begin
                if (!(alu_out.lt && (r_np != p2fl_pkg::MAX_POWER))) begin
                    n_state = p2fl_pkg::S_SRCH_ADDR;
                end
            end
            p2fl_pkg::S_SRCH_ADDR: begin
                if (r_idx >= r_count) begin
                    if (r_op == p2fl_pkg::OP_LOOKUP || full) begin
                        n_state = p2fl_pkg::S_DONE;
                    end else begin
                        n_state = p2fl_pkg::S_END_CHK;
                    end
                end else begin
                    n_state = p2fl_pkg::S_SRCH_CMP;
                end
            end
            p2fl_pkg::S_SRCH_CMP: begin
                if (alu_out.eq) begin
                    n_state = (r_op == p2fl_pkg::OP_LOOKUP) ? p2fl_pkg::S_DONE
                                                             : p2fl_pkg::S_SHIFT_RD;
                end else begin
                    n_state = p2fl_pkg::S_SRCH_ADDR;
                end
            end
            p2fl_pkg::S_SHIFT_RD: begin
                n_state = (idx_inc < r_count) ? p2fl_pkg::S_SHIFT_WR : p2fl_pkg::S_APPEND;
            end
            p2fl_pkg::S_SHIFT_WR: begin
                n_state = p2fl_pkg::S_SHIFT_RD;
            end
            p2fl_pkg::S_END_CHK: begin
                n_state = alu_out.lt ? p2fl_pkg::S_APPEND : p2fl_pkg::S_DONE;
            end
            p2fl_pkg::S_APPEND: begin
                n_state = p2fl_pkg::S_DONE;
            end
            default: begin
                n_state = p2fl_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_op      = r_op;
        n_pw      = r_pw;
        n_req     = r_req;
        n_off     = r_off;
        n_loaded  = r_loaded;
        n_np      = r_np;
        n_idx     = r_idx;
        n_count   = r_count;
        n_end     = r_end;
        n_status  = r_status;
        n_noff    = r_noff;
        n_npw     = r_npw;
        mem_we    = 1'b0;
        mem_waddr = r_idx[p2fl_pkg::IDX_W-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = r_idx[p2fl_pkg::IDX_W-1:0];

        case (r_state)
            p2fl_pkg::S_IDLE, p2fl_pkg::S_DONE: begin
                if (accept) begin
                    n_op     = i_cmd.opcode;
                    n_pw     = i_cmd.block_size_power;
                    n_req    = i_cmd.need_bytes;
                    n_off    = p2fl_pkg::to_off(i_cmd.current_offset);
                    n_loaded = i_cmd.entry_loaded;
                end
            end
            p2fl_pkg::S_DISPATCH: begin
                n_status = p2fl_pkg::ST_NO_CHANGE;
                n_noff   = '0;
                n_npw    = '0;
                n_idx    = '0;
                n_np     = r_pw;
                case (r_op)
                    p2fl_pkg::OP_RELEASE: begin
                        if (!r_loaded) begin
                            n_status = p2fl_pkg::ST_IGNORED;
                        end else if (full) begin
                            n_status = p2fl_pkg::ST_LIST_FULL;
                        end else begin
                            n_status = p2fl_pkg::ST_RELEASED;
                        end
                    end
                    p2fl_pkg::OP_RESIZE: begin
                        // The block already holds the required size.
                        if (!alu_out.lt) begin
                            n_noff = r_off;
                            n_npw  = r_pw;
                        end
                    end
                    default: begin
                        n_status = p2fl_pkg::ST_NO_CHANGE;
                    end
                endcase
            end
            p2fl_pkg::S_ROUND: begin
                if (alu_out.lt && (r_np != p2fl_pkg::MAX_POWER)) begin
                    n_np = r_np + p2fl_pkg::PWR_W'(1);
                end
            end
            p2fl_pkg::S_SRCH_ADDR: begin
                if (r_idx >= r_count) begin
                    if (r_op == p2fl_pkg::OP_LOOKUP) begin
                        n_status = p2fl_pkg::ST_NOT_FOUND;
                    end else if (full) begin
                        n_status = p2fl_pkg::ST_LIST_FULL;
                    end
                end
            end
            p2fl_pkg::S_SRCH_CMP: begin
                if (alu_out.eq) begin
                    n_noff   = mem_rdata.offset;
                    n_npw    = r_np;
                    n_status = (r_op == p2fl_pkg::OP_LOOKUP) ? p2fl_pkg::ST_FOUND
                                                              : p2fl_pkg::ST_FROM_LIST;
                end else begin
                    n_idx = idx_inc;
                end
            end
            p2fl_pkg::S_SHIFT_RD: begin
                // Fetch the following entry, or finish the removal.
                mem_raddr = idx_inc[p2fl_pkg::IDX_W-1:0];
                if (!(idx_inc < r_count)) begin
                    n_count = r_count - p2fl_pkg::CNT_W'(1);
                end
            end
            p2fl_pkg::S_SHIFT_WR: begin
                mem_we = 1'b1;
                n_idx  = idx_inc;
            end
            p2fl_pkg::S_END_CHK: begin
                if (alu_out.lt) begin
                    n_noff   = r_end;
                    n_npw    = r_np;
                    n_end    = alu_out.sum[p2fl_pkg::OFFSET_BITS-1:0];
                    n_status = p2fl_pkg::ST_AT_END;
                end else begin
                    n_status = p2fl_pkg::ST_END_OVERFLOW;
                end
            end
            p2fl_pkg::S_APPEND: begin
                mem_we           = 1'b1;
                mem_waddr        = r_count[p2fl_pkg::IDX_W-1:0];
                mem_wdata.power  = r_pw;
                mem_wdata.offset = r_off;
                n_count          = r_count + p2fl_pkg::CNT_W'(1);
            end
            default: begin
                n_idx = r_idx;
            end
        endcase

        if (i_cfg_we) begin
            n_end = i_cfg_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= p2fl_pkg::S_IDLE;
            r_count <= '0;
            r_end   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_end   <= n_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_pw     <= n_pw;
        r_req    <= n_req;
        r_off    <= n_off;
        r_loaded <= n_loaded;
        r_np     <= n_np;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_noff   <= n_noff;
        r_npw    <= n_npw;
    end

    assign o_done                  = r_state == p2fl_pkg::S_DONE;
    assign o_result.status         = r_status;
    assign o_result.new_offset     = p2fl_pkg::from_off(r_noff);
    assign o_result.new_size_power = r_npw;
    assign o_result.free_count     = p2fl_pkg::FCNT_W'(r_count);

endmodule

// ===== hdl/pow2_free_list_allocator_core.sv =====
// Power-of-two free list allocator: APB register port and sequencer.
// A resize that needs no change, an ignored or refused release and an unused opcode end
// straight after dispatch; a release appends one entry; a lookup, and a resize that grows,
// walk the list one entry at a time through the registered read port of the list memory.
// One command at a time, the next taken in the cycle of the one-cycle o_done beat, which
// the receiver cannot hold off. Synchronous active-low reset empties list and end pointer.
module pow2_free_list_allocator_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  p2fl_pkg::t_cmd               i_cmd,
    output logic                         o_done,
    output p2fl_pkg::t_result            o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [p2fl_pkg::PADDR_W-1:0] paddr,
    input  logic [p2fl_pkg::PDATA_W-1:0] pwdata,
    output logic [p2fl_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    logic [p2fl_pkg::REG_W-1:0] r_init_end;
    logic                       cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == p2fl_pkg::ADDR_INIT_END);
    assign prdata = (paddr == p2fl_pkg::ADDR_INIT_END) ? p2fl_pkg::PDATA_W'(r_init_end) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_end <= '0;
        end else if (cfg_we) begin
            r_init_end <= pwdata[p2fl_pkg::REG_W-1:0];
        end
    end

    p2fl_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_cmd     (i_cmd),
        .i_cfg_we  (cfg_we),
        .i_cfg_end (p2fl_pkg::to_off(pwdata[p2fl_pkg::REG_W-1:0])),
        .o_busy    (busy),
        .o_done    (o_done),
        .o_result  (o_result)
    );

endmodule

// ===== hdl/p2fl_checker.sv =====
// Port-level checks of the allocator core, attached by bind.
// Depends on p2fl_pkg and the ports of pow2_free_list_allocator_core.
module p2fl_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input p2fl_pkg::t_result o_result
);

    // An accepted command keeps the block busy in the following cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an accepted command");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while busy");

    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("two result beats in a row");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.status <= p2fl_pkg::ST_END_OVERFLOW))
        else $error("status code out of range");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.free_count <= p2fl_pkg::FCNT_W'(p2fl_pkg::LIST_DEPTH)))
        else $error("free count beyond list depth");

endmodule

bind pow2_free_list_allocator_core p2fl_checker u_p2fl_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

// ===== tb/p2fl_tb_pkg.sv =====
// Scoreboard for the power-of-two free list allocator testbench.
// Keeps its own copy of the free list and end pointer, and checks result beats.
// Depends on p2fl_pkg for the beat types, status codes and sizing constants.
`timescale 1ns / 1ps

package p2fl_tb_pkg;
    import p2fl_pkg::*;

    localparam logic [63:0] OFF_LIMIT = (64'd1 << OFFSET_BITS) - 64'd1;

    class alloc_scoreboard;
        logic [PWR_W-1:0]       free_power [LIST_DEPTH];
        logic [OFFSET_BITS-1:0] free_offset [LIST_DEPTH];
        int unsigned            free_entries;
        logic [OFFSET_BITS-1:0] end_ptr;
        t_result                expected_alloc [$];
        int                     errors;

        function new();
            free_entries = 0;
            end_ptr      = '0;
            errors       = 0;
        endfunction

        function void load_end(input logic [REG_W-1:0] value);
            end_ptr = value[OFFSET_BITS-1:0];
        endfunction

        function int first_fit(input logic [PWR_W-1:0] pw);
            for (int i = 0; i < free_entries; i++) begin
                if (free_power[i] == pw) return i;
            end
            return -1;
        endfunction

        function void push_free(input logic [PWR_W-1:0] pw, input logic [OFFSET_BITS-1:0] off);
            if (free_entries < LIST_DEPTH) begin
                free_power[free_entries]  = pw;
                free_offset[free_entries] = off;
                free_entries++;
            end
        endfunction

        // Works out the result beat of one accepted command and updates the list.
        function void note_command(input t_cmd c);
            t_result                r;
            int                     pos;
            int                     np;
            logic [63:0]            nsize;
            logic [OFFSET_BITS-1:0] off;
            r   = '0;
            off = c.current_offset[OFFSET_BITS-1:0];
            case (c.opcode)
                OP_RELEASE: begin
                    if (!c.entry_loaded) begin
                        r.status = ST_IGNORED;
                    end else if (free_entries >= LIST_DEPTH) begin
                        r.status = ST_LIST_FULL;
                    end else begin
                        push_free(c.block_size_power, off);
                        r.status = ST_RELEASED;
                    end
                end
                OP_RESIZE: begin
                    if (64'(c.need_bytes) <= (64'd1 << c.block_size_power)) begin
                        r.status         = ST_NO_CHANGE;
                        r.new_offset     = c.current_offset;
                        r.new_size_power = c.block_size_power;
                    end else begin
                        np = int'(c.block_size_power);
                        while (((64'd1 << np) < 64'(c.need_bytes)) && np < 31) np++;
                        nsize = 64'd1 << np;
                        pos   = first_fit(PWR_W'(np));
                        if (pos >= 0) begin
                            r.new_offset = free_offset[pos];
                            // Later entries move down to close the gap.
                            for (int i = pos; i + 1 < free_entries; i++) begin
                                free_power[i]  = free_power[i+1];
                                free_offset[i] = free_offset[i+1];
                            end
                            free_entries--;
                            push_free(c.block_size_power, off);
                            r.status         = ST_FROM_LIST;
                            r.new_size_power = PWR_W'(np);
                        end else if (free_entries >= LIST_DEPTH) begin
                            r.status = ST_LIST_FULL;
                        end else if (64'(end_ptr) + nsize > OFF_LIMIT) begin
                            r.status = ST_END_OVERFLOW;
                        end else begin
                            push_free(c.block_size_power, off);
                            r.new_offset     = end_ptr;
                            end_ptr          = OFFSET_BITS'(64'(end_ptr) + nsize);
                            r.status         = ST_AT_END;
                            r.new_size_power = PWR_W'(np);
                        end
                    end
                end
                OP_LOOKUP: begin
                    pos = first_fit(c.block_size_power);
                    if (pos >= 0) begin
                        r.status         = ST_FOUND;
                        r.new_offset     = free_offset[pos];
                        r.new_size_power = c.block_size_power;
                    end else begin
                        r.status = ST_NOT_FOUND;
                    end
                end
                default: r.status = ST_NO_CHANGE;
            endcase
            r.free_count = FCNT_W'(free_entries);
            expected_alloc.push_back(r);
        endfunction

        function void check_result(input t_result got);
            t_result want;
            if (expected_alloc.size() == 0) begin
                $error("result beat with nothing expected: status %0d", got.status);
                errors++;
                return;
            end
            want = expected_alloc.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.new_offset !== want.new_offset) begin
                $error("new_offset: expected %h, got %h", want.new_offset, got.new_offset);
                errors++;
            end
            if (got.new_size_power !== want.new_size_power) begin
                $error("new_size_power: expected %0d, got %0d",
                       want.new_size_power, got.new_size_power);
                errors++;
            end
            if (got.free_count !== want.free_count) begin
                $error("free_count: expected %0d, got %0d", want.free_count, got.free_count);
                errors++;
            end
        endfunction

        function void check_drained();
            if (expected_alloc.size() != 0) begin
                $error("%0d result beats never arrived", expected_alloc.size());
                errors++;
            end
        endfunction

        function int waiting();
            return expected_alloc.size();
        endfunction
    endclass

endpackage

// ===== tb/tb_top.sv =====
// Top-level testbench for pow2_free_list_allocator_core: directed and random commands,
// APB writes of the end pointer between phases, result beats checked by the scoreboard.
// Depends on p2fl_pkg and p2fl_tb_pkg.
`timescale 1ns / 1ps

module tb_top;
    import p2fl_pkg::*;
    import p2fl_tb_pkg::*;

    localparam logic [1:0]       OP_UNUSED        = 2'd3;
    localparam logic [REG_W-1:0] OFF_ALL          = '1;
    localparam logic [REQ_W-1:0] REQ_ALL          = '1;
    localparam int               RANDOM_PER_PHASE = 226;
    localparam int               PHASES           = 5;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_cmd                 i_cmd;
    logic                 o_done;
    t_result              o_result;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    alloc_scoreboard sb = new();

    pow2_free_list_allocator_core i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 i_clk = ~i_clk;

    // Result beats cannot be held off, so every strobe is checked as it comes.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) sb.check_result(o_result);
    end

    function automatic t_cmd make_cmd(input logic [1:0] op, input logic [PWR_W-1:0] pw,
                                      input logic [REQ_W-1:0] req,
                                      input logic [REG_W-1:0] off, input logic loaded);
        t_cmd c;
        c.opcode           = op;
        c.block_size_power = pw;
        c.need_bytes       = req;
        c.current_offset   = off;
        c.entry_loaded     = loaded;
        return c;
    endfunction

    function automatic logic [REG_W-1:0] rand_offset();
        int unsigned m;
        m = $urandom_range(0, 19);
        if (m == 0) return '0;
        if (m == 1) return OFF_ALL;
        return {8'($urandom), 32'($urandom)};
    endfunction

    // Mostly small powers, so that releases, resizes and lookups meet in the list.
    function automatic logic [PWR_W-1:0] pick_power();
        if ($urandom_range(0, 9) < 8) return PWR_W'($urandom_range(0, 10));
        return PWR_W'($urandom_range(0, 31));
    endfunction

    function automatic logic [REQ_W-1:0] resize_need(input logic [PWR_W-1:0] pw);
        int unsigned m;
        int unsigned np;
        int unsigned lo;
        int unsigned hi;
        m = $urandom_range(0, 99);
        if (m < 15) return REQ_W'($urandom_range(0, (pw >= 31) ? 32'h7fff_ffff : (32'd1 << pw)));
        if (m < 25) return REQ_W'($urandom);
        np = pw + $urandom_range(1, 3);
        if (np > 31) np = 31;
        lo = (32'd1 << (np - 1)) + 1;
        hi = (np == 31) ? 32'h7fff_ffff : (32'd1 << np);
        return REQ_W'($urandom_range(lo, hi));
    endfunction

    function automatic t_cmd random_item();
        t_cmd c;
        int   r;
        c.block_size_power = pick_power();
        c.need_bytes       = REQ_W'($urandom);
        c.current_offset   = rand_offset();
        c.entry_loaded     = 1'($urandom);
        r = $urandom_range(0, 99);
        if (r < 28) begin
            c.opcode       = OP_RELEASE;
            c.entry_loaded = (r < 22);
        end else if (r < 65) begin
            c.opcode     = OP_RESIZE;
            c.need_bytes = resize_need(c.block_size_power);
        end else if (r < 92) begin
            c.opcode = OP_LOOKUP;
        end else begin
            c.opcode = OP_UNUSED;
        end
        return c;
    endfunction

    function automatic int pick_gap(input logic burst);
        int unsigned m;
        if (burst) return 0;
        m = $urandom_range(0, 99);
        if (m < 55) return 0;
        if (m < 90) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // Start stays high from one command to the next when there is no gap.
    task automatic issue(input t_cmd c, input int gap);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_cmd <= random_item();
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        sb.note_command(c);
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.waiting() != 0 || busy) @(negedge i_clk);
    endtask

    // Writes the end pointer register and reads it back.
    task automatic write_end_reg(input logic [PDATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_INIT_END;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.load_end(data[REG_W-1:0]);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 64'(data[REG_W-1:0])) begin
            $error("prdata: expected %h, got %h", 64'(data[REG_W-1:0]), prdata);
            sb.errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        logic [REG_W-1:0] phase_end;
        logic             burst;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        burst   = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Junk above the register width must be dropped.
        write_end_reg({24'hA5A5A5, 40'h0});

        issue(make_cmd(OP_LOOKUP, 5'd0, '0, '0, 1'b1), pick_gap(1'b0));
        issue(make_cmd(OP_RELEASE, 5'd5, 31'd7, 40'h12345, 1'b0), pick_gap(1'b0));
        issue(make_cmd(OP_RELEASE, 5'd3, '0, OFF_ALL, 1'b1), pick_gap(1'b0));
        issue(make_cmd(OP_RELEASE, 5'd31, REQ_ALL, '0, 1'b1), pick_gap(1'b0));
        issue(make_cmd(OP_RESIZE, 5'd0, '0, OFF_ALL, 1'b1), pick_gap(1'b0));
        issue(make_cmd(OP_RESIZE, 5'd2, 31'd4, 40'h55, 1'b0), pick_gap(1'b0));
        issue(make_cmd(OP_RESIZE, 5'd2, 31'd5, 40'hAAAA, 1'b1), pick_gap(1'b0));
        issue(make_cmd(OP_LOOKUP, 5'd31, '0, '0, 1'b0), pick_gap(1'b0));
        issue(make_cmd(OP_RESIZE, 5'd0, REQ_ALL, 40'h1, 1'b1), pick_gap(1'b0));
        issue(make_cmd(OP_RESIZE, 5'd30, 31'h4000_0001, 40'h777, 1'b1), pick_gap(1'b0));
        issue(make_cmd(OP_LOOKUP, 5'd2, REQ_ALL, OFF_ALL, 1'b1), pick_gap(1'b0));
        issue(make_cmd(OP_UNUSED, 5'd31, REQ_ALL, OFF_ALL, 1'b1), pick_gap(1'b0));
        issue(make_cmd(OP_RESIZE, 5'd31, REQ_ALL, 40'h9_0000, 1'b1), pick_gap(1'b0));
        issue(make_cmd(OP_RESIZE, 5'd0, 31'd1, 40'h42, 1'b1), pick_gap(1'b0));
        issue(make_cmd(OP_RESIZE, 5'd0, 31'd2, 40'h43, 1'b1), pick_gap(1'b0));
        issue(make_cmd(OP_LOOKUP, 5'd30, '0, '0, 1'b0), pick_gap(1'b0));

        // An end pointer 16 below the top overflows a 16-byte block; 17 below just fits.
        drain();
        write_end_reg(64'(OFF_ALL - 40'd15));
        issue(make_cmd(OP_RESIZE, 5'd3, 31'd16, 40'h100, 1'b1), pick_gap(1'b0));
        drain();
        write_end_reg(64'(OFF_ALL - 40'd16));
        issue(make_cmd(OP_RESIZE, 5'd3, 31'd16, 40'h200, 1'b1), pick_gap(1'b0));
        issue(make_cmd(OP_RESIZE, 5'd3, 31'd9, 40'h300, 1'b1), pick_gap(1'b0));

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0:       phase_end = {8'($urandom), 32'($urandom)};
                1:       phase_end = OFF_ALL;
                2:       phase_end = OFF_ALL - 40'hF_FFFF;
                3:       phase_end = '0;
                default: phase_end = REG_W'($urandom_range(0, 32'h000F_FFFF));
            endcase
            write_end_reg(64'(phase_end));
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                if (k % 50 == 0) burst = ($urandom_range(0, 3) == 0);
                issue(random_item(), pick_gap(burst));
            end
        end

        drain();
        repeat (64) @(posedge i_clk);
        sb.check_drained();
        if (sb.errors == 0) begin
            $display("pow2_free_list_allocator_core verification clean");
        end else begin
            $display("pow2_free_list_allocator_core verification failed");
        end
        $finish;
    end

    initial begin
        #150_000_000;
        $display("pow2_free_list_allocator_core verification failed");
        $finish;
    end

endmodule
